@@ sv/saabb_pkg.sv @@
// ----------------------------------------------------------------------------
// saabb_pkg
// Shared constants and types for the swept box collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package saabb_pkg;

   localparam int COORD_BITS_DEF     = 24;
   localparam int TIME_FRAC_BITS_DEF = 16;

   localparam logic signed [1:0] NRM_ZERO = 2'sb00;
   localparam logic signed [1:0] NRM_POS  = 2'sb01;
   localparam logic signed [1:0] NRM_NEG  = 2'sb11;

   typedef struct packed {
      logic ok;
      logic xs;
      logic ys;
      logic dxpos;
      logic dypos;
   } side_type;

endpackage

`default_nettype wire

@@ sv/saabb_div.sv @@
// ----------------------------------------------------------------------------
// saabb_div
// Pipelined restoring divider, one quotient bit per stage, signed result
// truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module saabb_div #(
   parameter int MAG_BITS = saabb_pkg::COORD_BITS_DEF + saabb_pkg::TIME_FRAC_BITS_DEF,
   parameter int DEN_BITS = saabb_pkg::COORD_BITS_DEF + 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  wire  [MAG_BITS-1:0]        in_num,
   input  wire  [DEN_BITS-1:0]        in_den,
   input  wire                        in_neg,
   output logic                       out_valid,
   output logic signed [MAG_BITS:0]   out_quo
);

   logic                vld_ff [MAG_BITS];
   logic [DEN_BITS-1:0] rem_ff [MAG_BITS];
   logic [DEN_BITS-1:0] den_ff [MAG_BITS];
   logic [MAG_BITS-1:0] qn_ff  [MAG_BITS];
   logic                neg_ff [MAG_BITS];
   logic                out_valid_ff;
   logic signed [MAG_BITS:0] quo_ff;

   for (genvar k = 0; k < MAG_BITS; k++) begin : g_stage
      logic                src_vld;
      logic [DEN_BITS-1:0] src_rem;
      logic [DEN_BITS-1:0] src_den;
      logic [MAG_BITS-1:0] src_qn;
      logic                src_neg;
      logic [DEN_BITS:0]   part;
      logic [DEN_BITS:0]   diff;
      logic                ge;
      logic [DEN_BITS-1:0] rem_in;
      logic [MAG_BITS-1:0] qn_in;

      if (k == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_rem = '0;
         assign src_den = in_den;
         assign src_qn  = in_num;
         assign src_neg = in_neg;
      end else begin : g_next
         assign src_vld = vld_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_qn  = qn_ff[k-1];
         assign src_neg = neg_ff[k-1];
      end

      always_comb begin
         part   = {src_rem, src_qn[MAG_BITS-1]};
         diff   = part - {1'b0, src_den};
         ge     = (part >= {1'b0, src_den});
         rem_in = ge ? diff[DEN_BITS-1:0] : part[DEN_BITS-1:0];
         qn_in  = {src_qn[MAG_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= src_vld;
         end
         rem_ff[k] <= rem_in;
         den_ff[k] <= src_den;
         qn_ff[k]  <= qn_in;
         neg_ff[k] <= src_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[MAG_BITS-1];
      end
      if (neg_ff[MAG_BITS-1]) begin
         quo_ff <= -$signed({1'b0, qn_ff[MAG_BITS-1]});
      end else begin
         quo_ff <= $signed({1'b0, qn_ff[MAG_BITS-1]});
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = quo_ff;

endmodule

`default_nettype wire

@@ sv/swept_aabb_collision.sv @@
// ----------------------------------------------------------------------------
// swept_aabb_collision
// Swept axis-aligned box test: broad phase, per-axis entry and exit times
// through four pipelined dividers, hit flag, entry time and face normal.
//
//   channel   ports                  handshake
//   request   start, req_*           start high and busy low
//   result    rsp_strobe, rsp_*      one-cycle strobe, no back-pressure
//
// One request per cycle. A request passes through the stage 1 registers, the
// bit-per-stage divider pipeline and the output registers. busy stays low.
// Synchronous reset clears all valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_aabb_collision #(
   parameter int COORD_BITS     = saabb_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = saabb_pkg::TIME_FRAC_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  signed [COORD_BITS-1:0]  req_move_left,
   input  wire  signed [COORD_BITS-1:0]  req_move_top,
   input  wire  signed [COORD_BITS-1:0]  req_move_right,
   input  wire  signed [COORD_BITS-1:0]  req_move_bottom,
   input  wire  signed [COORD_BITS-1:0]  req_static_left,
   input  wire  signed [COORD_BITS-1:0]  req_static_top,
   input  wire  signed [COORD_BITS-1:0]  req_static_right,
   input  wire  signed [COORD_BITS-1:0]  req_static_bottom,
   input  wire  signed [COORD_BITS-1:0]  req_move_dx,
   input  wire  signed [COORD_BITS-1:0]  req_move_dy,
   input  wire  signed [COORD_BITS-1:0]  req_other_dx,
   input  wire  signed [COORD_BITS-1:0]  req_other_dy,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [TIME_FRAC_BITS:0]       rsp_entry_time,
   output logic signed [1:0]             rsp_normal_x,
   output logic signed [1:0]             rsp_normal_y
);

   localparam int W   = COORD_BITS + 1;
   localparam int B   = COORD_BITS + 2;
   localparam int MB  = COORD_BITS + TIME_FRAC_BITS;
   localparam int LAT = MB + 1;

   localparam logic signed [MB:0] T_ONE = (MB+1)'(1) <<< TIME_FRAC_BITS;

   // stage 1: relative motion, swept box, distances
   logic signed [W-1:0] dx, dy;
   logic signed [B-1:0] bl, bt, br, bb;
   logic signed [W-1:0] xent, xext, yent, yext;
   logic signed [W-1:0] adx, ady;
   logic                xs, ys, dxpos, dypos, dxneg, dyneg, miss;
   saabb_pkg::side_type side_in;

   always_comb begin
      dx    = W'(req_move_dx) - W'(req_other_dx);
      dy    = W'(req_move_dy) - W'(req_other_dy);
      xs    = (dx == '0);
      ys    = (dy == '0);
      dxpos = (dx > 0);
      dypos = (dy > 0);
      dxneg = dx[W-1];
      dyneg = dy[W-1];
      bl = dxpos ? B'(req_move_left)  : B'(req_move_left)  + B'(dx);
      bt = dypos ? B'(req_move_top)   : B'(req_move_top)   + B'(dy);
      br = dxpos ? B'(req_move_right) + B'(dx) : B'(req_move_right);
      bb = dypos ? B'(req_move_bottom) + B'(dy) : B'(req_move_bottom);
      miss = (br < B'(req_static_left)) || (bl > B'(req_static_right)) ||
             (bb < B'(req_static_top))  || (bt > B'(req_static_bottom));
      xent = dxpos ? W'(req_static_left) - W'(req_move_right)
                   : W'(req_static_right) - W'(req_move_left);
      xext = dxpos ? W'(req_static_right) - W'(req_move_left)
                   : W'(req_static_left) - W'(req_move_right);
      yent = dypos ? W'(req_static_top) - W'(req_move_bottom)
                   : W'(req_static_bottom) - W'(req_move_top);
      yext = dypos ? W'(req_static_bottom) - W'(req_move_top)
                   : W'(req_static_top) - W'(req_move_bottom);
      adx = dxneg ? -dx : dx;
      ady = dyneg ? -dy : dy;
      side_in.ok    = !miss && !(xs && ys);
      side_in.xs    = xs;
      side_in.ys    = ys;
      side_in.dxpos = dxpos;
      side_in.dypos = dypos;
   end

   logic                  s1_vld_ff;
   saabb_pkg::side_type   s1_side_ff;
   logic [MB-1:0]         s1_num_ff [4];
   logic                  s1_neg_ff [4];
   logic [W-1:0]          s1_adx_ff, s1_ady_ff;
   logic signed [W-1:0]   dst [4];
   logic                  dneg [4];

   always_comb begin
      dst[0] = xent; dst[1] = xext; dst[2] = yent; dst[3] = yext;
      dneg[0] = dxneg; dneg[1] = dxneg; dneg[2] = dyneg; dneg[3] = dyneg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
      s1_side_ff <= side_in;
      s1_adx_ff  <= adx;
      s1_ady_ff  <= ady;
      for (int i = 0; i < 4; i++) begin
         s1_num_ff[i] <= {(dst[i][W-1] ? COORD_BITS'(-dst[i]) : COORD_BITS'(dst[i])),
                          {TIME_FRAC_BITS{1'b0}}};
         s1_neg_ff[i] <= dst[i][W-1] ^ dneg[i];
      end
   end

   // dividers
   logic                dv_vld [4];
   logic signed [MB:0]  dv_quo [4];

   for (genvar i = 0; i < 4; i++) begin : g_div
      saabb_div #(.MAG_BITS(MB), .DEN_BITS(W)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s1_vld_ff),
         .in_num    (s1_num_ff[i]),
         .in_den    ((i < 2) ? s1_adx_ff : s1_ady_ff),
         .in_neg    (s1_neg_ff[i]),
         .out_valid (dv_vld[i]),
         .out_quo   (dv_quo[i])
      );
   end

   saabb_pkg::side_type side_pipe_ff [LAT];

   always_ff @(posedge clock) begin
      side_pipe_ff[0] <= s1_side_ff;
      for (int i = 1; i < LAT; i++) begin
         side_pipe_ff[i] <= side_pipe_ff[i-1];
      end
   end

   // final stage: reject tests, normal choice
   saabb_pkg::side_type sd;
   logic signed [MB:0]  txe, txx, tye, tyx, te, tx;
   logic                xneg, yneg, rej, hit_in, xlater, vld_in;
   logic signed [1:0]   nx_in, ny_in;

   always_comb begin
      sd  = side_pipe_ff[LAT-1];
      txe = dv_quo[0]; txx = dv_quo[1]; tye = dv_quo[2]; tyx = dv_quo[3];
      vld_in = dv_vld[0] && dv_vld[1] && dv_vld[2] && dv_vld[3];
      xneg = sd.xs || txe[MB];
      yneg = sd.ys || tye[MB];
      if (sd.xs) begin
         te = tye; tx = tyx;
      end else if (sd.ys) begin
         te = txe; tx = txx;
      end else begin
         te = (txe > tye) ? txe : tye;
         tx = (txx < tyx) ? txx : tyx;
      end
      rej = (xneg && yneg) || (!sd.xs && txe > T_ONE) || (!sd.ys && tye > T_ONE) ||
            (te > tx);
      hit_in = sd.ok && !rej;
      xlater = sd.ys || (!sd.xs && txe > tye);
      nx_in  = saabb_pkg::NRM_ZERO;
      ny_in  = saabb_pkg::NRM_ZERO;
      if (hit_in) begin
         if (xlater) begin
            nx_in = sd.dxpos ? saabb_pkg::NRM_NEG : saabb_pkg::NRM_POS;
         end else begin
            ny_in = sd.dypos ? saabb_pkg::NRM_NEG : saabb_pkg::NRM_POS;
         end
      end
   end

   logic                    strobe_ff, hit_ff;
   logic [TIME_FRAC_BITS:0] entry_ff;
   logic signed [1:0]       nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_in;
      end
      hit_ff   <= hit_in;
      entry_ff <= hit_in ? te[TIME_FRAC_BITS:0] : '0;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
   end

   assign busy           = 1'b0;
   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_entry_time = entry_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;

endmodule

`default_nettype wire

@@ sv/saabb_checker.sv @@
// ----------------------------------------------------------------------------
// saabb_checker
// Port-level checks on results of the swept box collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module saabb_checker #(
   parameter int COORD_BITS     = saabb_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = saabb_pkg::TIME_FRAC_BITS_DEF
) (
   input wire                       clock,
   input wire                       reset,
   input wire                       start,
   input wire                       busy,
   input wire                       rsp_strobe,
   input wire                       rsp_hit,
   input wire [TIME_FRAC_BITS:0]    rsp_entry_time,
   input wire signed [1:0]          rsp_normal_x,
   input wire signed [1:0]          rsp_normal_y
);

   localparam int LAT = COORD_BITS + TIME_FRAC_BITS + 3;
   localparam logic [TIME_FRAC_BITS:0] ONE = (TIME_FRAC_BITS+1)'(1) << TIME_FRAC_BITS;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |->
         rsp_entry_time == '0 && rsp_normal_x == 2'sb00 && rsp_normal_y == 2'sb00)
      else $error("miss with nonzero payload");

   a_hit_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |->
         (rsp_normal_x == 2'sb00) != (rsp_normal_y == 2'sb00) && rsp_entry_time <= ONE)
      else $error("hit without single normal or time above one");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without matching request");

endmodule

bind swept_aabb_collision saabb_checker #(
   .COORD_BITS     (COORD_BITS),
   .TIME_FRAC_BITS (TIME_FRAC_BITS)
) u_saabb_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_hit        (rsp_hit),
   .rsp_entry_time (rsp_entry_time),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y)
);

`default_nettype wire
